[rtl/ddo_pkg.sv]
`timescale 1ns / 1ps
// Shared types, widths and constants for the differential-drive odometry block.
// No dependencies; imported by ddo_cordic, ddo_mac, diff_drive_odometry_top and tb_top.
package ddo_pkg;

  // Fixed field and datapath widths
  localparam int TICK_W      = 16;
  localparam int REG_W       = 24;
  localparam int POS_W       = 32;
  localparam int HOUT_W      = 16;
  localparam int CFG_ADDR_W  = 2;
  localparam int IN_DATA_W   = 2 * TICK_W;
  localparam int OUT_DATA_W  = 2 * POS_W + HOUT_W;

  // Shared multiplier: chunk of a 41-bit operand times a 25-bit signed operand
  localparam int MUL_A_W     = 22;
  localparam int MUL_B_W     = 25;
  localparam int PROD_W      = MUL_A_W + MUL_B_W;
  localparam int SPLIT       = 21;
  localparam int DIST_W      = 40;
  localparam int SUM_W       = 41;
  localparam int ACC_W       = 68;
  localparam int DX_W        = 44;

  // CORDIC datapath
  localparam int CXY_W       = 33;
  localparam int TRIG_W      = 22;
  localparam int TRIG_SH     = 10;
  localparam int ATAN_N      = 24;
  localparam int ATAN_IDX_W  = 5;
  localparam logic signed [CXY_W-1:0] CORDIC_K = 33'sd652032874;

  // Register reset values
  localparam logic [REG_W-1:0] RST_LEFT_MPT   = 24'd17202;
  localparam logic [REG_W-1:0] RST_RIGHT_MPT  = 24'd17311;
  localparam logic [REG_W-1:0] RST_ANGLE_GAIN = 24'd4238490;

  localparam logic signed [POS_W-1:0] POS_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [POS_W-1:0] POS_MIN = 32'sh8000_0000;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_LEFT_MPT   = 2'd0,
    CFG_RIGHT_MPT  = 2'd1,
    CFG_ANGLE_GAIN = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic load;
    logic add;
  } mac_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } cd_stat_t;

  typedef enum logic [1:0] {
    CD_IDLE,
    CD_RUN,
    CD_FIX,
    CD_DONE
  } cd_state_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_ML,
    ST_MR,
    ST_DL,
    ST_DR,
    ST_HL,
    ST_HH,
    ST_HW,
    ST_HS,
    ST_CW,
    ST_XL,
    ST_XH,
    ST_YL,
    ST_YH,
    ST_XU,
    ST_YC,
    ST_YU,
    ST_DONE
  } ddo_state_t;

  // atan(2^-i) in 2^32-per-turn units
  function automatic logic [31:0] atan_lookup(input logic [ATAN_IDX_W-1:0] idx);
    logic [31:0] v;
    unique case (idx)
      5'd0:  v = 32'd536870912;
      5'd1:  v = 32'd316933406;
      5'd2:  v = 32'd167458907;
      5'd3:  v = 32'd85004756;
      5'd4:  v = 32'd42667331;
      5'd5:  v = 32'd21354465;
      5'd6:  v = 32'd10679838;
      5'd7:  v = 32'd5340245;
      5'd8:  v = 32'd2670163;
      5'd9:  v = 32'd1335087;
      5'd10: v = 32'd667544;
      5'd11: v = 32'd333772;
      5'd12: v = 32'd166886;
      5'd13: v = 32'd83443;
      5'd14: v = 32'd41722;
      5'd15: v = 32'd20861;
      5'd16: v = 32'd10430;
      5'd17: v = 32'd5215;
      5'd18: v = 32'd2608;
      5'd19: v = 32'd1304;
      5'd20: v = 32'd652;
      5'd21: v = 32'd326;
      5'd22: v = 32'd163;
      5'd23: v = 32'd81;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage

[rtl/diff_drive_odometry_top.sv]
`timescale 1ns / 1ps
// Top level of the differential-drive odometry pose tracker.
// Depends on ddo_pkg, ddo_mac and ddo_cordic.
//
// Usage:
//   in_*  : one beat per item. tuser[0] = kind (0 encoder update, 1 clear pose),
//           tdata = signed left and right tick deltas.
//   out_* : one beat per item with x, y (Q16.16 by default), heading as a
//           16-bit binary angle and a saturation flag in tuser.
//   cfg_* : register writes (left/right meters per tick, angle gain), always
//           ready; write only while the block is idle.
// Sequence: an update item runs from accept to out_tvalid through a CORDIC
//   start, one micro-rotation per cycle, a sign fix-up, then the x and y step
//   products, rounding and saturating adds, and one output load. The
//   multiplier works the wheel distances and heading step while the CORDIC
//   runs. in_tready returns with out_tvalid, so a new update is accepted only
//   once the previous item has reached its output load; a clear goes straight
//   from accept to the output load and frees the input the same way.
// Reset: synchronous, active low; clears the pose and heading to zero and
//   loads the register defaults.
// Stall: the result sits in an output register; the block accepts the next
//   item while it waits and holds the following result until the beat is taken.
module diff_drive_odometry_top #(
  parameter int ANGLE_BITS    = 16,
  parameter int POS_FRAC_BITS = 16,
  parameter int CORDIC_ITERS  = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // Input stream
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [ddo_pkg::IN_DATA_W-1:0]       in_tdata,   // [15:0] left_ticks, [31:16] right_ticks
  input  logic [0:0]                          in_tuser,   // [0] kind
  // Result stream
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [ddo_pkg::OUT_DATA_W-1:0]      out_tdata,  // [31:0] x_pos, [63:32] y_pos,
                                                          // [79:64] heading_out
  output logic [0:0]                          out_tuser,  // [0] saturated
  // Configuration writes
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [ddo_pkg::CFG_ADDR_W-1:0]      cfg_addr,
  input  logic [ddo_pkg::REG_W-1:0]           cfg_data
);
  import ddo_pkg::*;

  localparam int RND_SH = 45 - POS_FRAC_BITS;
  localparam logic signed [ACC_W-1:0] RND_HALF = ACC_W'(1) << (RND_SH - 1);
  localparam logic [ACC_W-1:0]        DH_HALF  = ACC_W'(1) << 31;

  ddo_state_t state_r, state_nxt;

  // Configuration registers
  logic [REG_W-1:0] lmpt_r, rmpt_r, gain_r;

  // Pose
  logic signed [POS_W-1:0]  pos_x_r, pos_y_r;
  logic [ANGLE_BITS-1:0]    heading_r;
  logic                     sat_r;

  // Per-item working registers
  logic signed [TICK_W-1:0] tl_r, tr_r;
  logic signed [DIST_W-1:0] dl_r;
  logic signed [SUM_W-1:0]  sum_r, diff_r;
  logic [ANGLE_BITS-1:0]    dh_r;
  logic signed [TRIG_W-1:0] cos_r, sin_r;
  logic signed [DX_W-1:0]   dx_r, dy_r;

  // Output register
  logic                     out_valid_r;
  logic [OUT_DATA_W-1:0]    out_data_r;
  logic                     out_user_r;

  // Shared units
  mac_ctl_t                  mac_ctl;
  logic signed [MUL_A_W-1:0] mac_a;
  logic signed [MUL_B_W-1:0] mac_b;
  logic signed [ACC_W-1:0]   acc;
  cd_stat_t                  cd_stat;
  logic                      cd_start;
  logic signed [TRIG_W-1:0]  cos_q20, sin_q20;

  logic                      in_acc, out_load;
  logic signed [DIST_W-1:0]  acc_dist;
  logic signed [ACC_W-1:0]   rnd_sum, rnd_shr;
  logic signed [DX_W-1:0]    rnd_val;
  logic [ACC_W-1:0]          dh_acc;
  logic signed [POS_W-1:0]   upd_base, upd_val;
  logic signed [DX_W-1:0]    upd_delta, upd_sum;
  logic                      upd_clip;
  logic [HOUT_W-1:0]         hout;

  ddo_mac u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (mac_ctl),
    .op_a  (mac_a),
    .op_b  (mac_b),
    .acc   (acc)
  );

  ddo_cordic #(
    .ANGLE_BITS   (ANGLE_BITS),
    .CORDIC_ITERS (CORDIC_ITERS)
  ) u_cordic (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (cd_start),
    .angle   (heading_r),
    .stat    (cd_stat),
    .cos_q20 (cos_q20),
    .sin_q20 (sin_q20)
  );

  // Sequencer: next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_tvalid) state_nxt = in_tuser[0] ? ST_DONE : ST_ML;
      ST_ML:   state_nxt = ST_MR;
      ST_MR:   state_nxt = ST_DL;
      ST_DL:   state_nxt = ST_DR;
      ST_DR:   state_nxt = ST_HL;
      ST_HL:   state_nxt = ST_HH;
      ST_HH:   state_nxt = ST_HW;
      ST_HW:   state_nxt = ST_HS;
      ST_HS:   state_nxt = ST_CW;
      ST_CW:   if (cd_stat.done) state_nxt = ST_XL;
      ST_XL:   state_nxt = ST_XH;
      ST_XH:   state_nxt = ST_YL;
      ST_YL:   state_nxt = ST_YH;
      ST_YH:   state_nxt = ST_XU;
      ST_XU:   state_nxt = ST_YC;
      ST_YC:   state_nxt = ST_YU;
      ST_YU:   state_nxt = ST_DONE;
      ST_DONE: if (!out_valid_r || out_tready) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Sequencer: outputs and multiplier operand selection.
  // Wide operands go through the multiplier as a low unsigned chunk (load)
  // and a high signed chunk (add, shifted by SPLIT).
  always_comb begin
    in_tready = (state_r == ST_IDLE);
    in_acc    = in_tvalid && in_tready;
    cd_start  = in_acc && !in_tuser[0];
    out_load  = (state_r == ST_DONE) && (!out_valid_r || out_tready);
    mac_ctl   = '0;
    mac_a     = '0;
    mac_b     = '0;
    unique case (state_r)
      ST_ML: begin
        mac_ctl.load = 1'b1;
        mac_a        = MUL_A_W'(tl_r);
        mac_b        = MUL_B_W'(lmpt_r);
      end
      ST_MR: begin
        mac_ctl.load = 1'b1;
        mac_a        = MUL_A_W'(tr_r);
        mac_b        = MUL_B_W'(rmpt_r);
      end
      ST_HL: begin
        mac_ctl.load = 1'b1;
        mac_a        = MUL_A_W'(diff_r[SPLIT-1:0]);
        mac_b        = MUL_B_W'(gain_r);
      end
      ST_HH: begin
        mac_ctl.add = 1'b1;
        mac_a       = MUL_A_W'($signed(diff_r[SUM_W-1:SPLIT]));
        mac_b       = MUL_B_W'(gain_r);
      end
      ST_XL: begin
        mac_ctl.load = 1'b1;
        mac_a        = MUL_A_W'(sum_r[SPLIT-1:0]);
        mac_b        = MUL_B_W'(cos_r);
      end
      ST_XH: begin
        mac_ctl.add = 1'b1;
        mac_a       = MUL_A_W'($signed(sum_r[SUM_W-1:SPLIT]));
        mac_b       = MUL_B_W'(cos_r);
      end
      ST_YL: begin
        mac_ctl.load = 1'b1;
        mac_a        = MUL_A_W'(sum_r[SPLIT-1:0]);
        mac_b        = MUL_B_W'(sin_r);
      end
      ST_YH: begin
        mac_ctl.add = 1'b1;
        mac_a       = MUL_A_W'($signed(sum_r[SUM_W-1:SPLIT]));
        mac_b       = MUL_B_W'(sin_r);
      end
      default: begin
        mac_ctl = '0;
      end
    endcase
  end

  // Accumulator taps: wheel distance, rounded position step, heading step
  always_comb begin
    acc_dist = $signed(acc[DIST_W-1:0]);
    rnd_sum  = acc + RND_HALF;
    rnd_shr  = rnd_sum >>> RND_SH;
    rnd_val  = rnd_shr[DX_W-1:0];
    dh_acc   = acc + DH_HALF;
  end

  // One saturating adder serves both x and y
  always_comb begin
    upd_base  = (state_r == ST_XU) ? pos_x_r : pos_y_r;
    upd_delta = (state_r == ST_XU) ? dx_r : dy_r;
    upd_sum   = DX_W'(upd_base) + upd_delta;
    upd_clip  = !((&upd_sum[DX_W-1:POS_W-1]) || !(|upd_sum[DX_W-1:POS_W-1]));
    if (upd_clip) begin
      upd_val = upd_sum[DX_W-1] ? POS_MIN : POS_MAX;
    end else begin
      upd_val = upd_sum[POS_W-1:0];
    end
  end

  // Rescale heading to 65536 per turn
  generate
    if (ANGLE_BITS >= HOUT_W) begin : g_hout_shr
      assign hout = heading_r[ANGLE_BITS-1 -: HOUT_W];
    end else begin : g_hout_shl
      assign hout = {heading_r, {(HOUT_W - ANGLE_BITS){1'b0}}};
    end
  endgenerate

  // Control, configuration and pose
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      lmpt_r      <= RST_LEFT_MPT;
      rmpt_r      <= RST_RIGHT_MPT;
      gain_r      <= RST_ANGLE_GAIN;
      pos_x_r     <= '0;
      pos_y_r     <= '0;
      heading_r   <= '0;
      sat_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid) begin
        unique case (cfg_addr)
          CFG_LEFT_MPT:   lmpt_r <= cfg_data;
          CFG_RIGHT_MPT:  rmpt_r <= cfg_data;
          CFG_ANGLE_GAIN: gain_r <= cfg_data;
          default: ;
        endcase
      end
      if (in_acc) begin
        sat_r <= 1'b0;
        if (in_tuser[0]) begin
          pos_x_r   <= '0;
          pos_y_r   <= '0;
          heading_r <= '0;
        end
      end
      // Heading advances only after the CORDIC has taken the old value
      if (state_r == ST_XU) begin
        pos_x_r   <= upd_val;
        sat_r     <= upd_clip;
        heading_r <= heading_r + dh_r;
      end
      if (state_r == ST_YU) begin
        pos_y_r <= upd_val;
        sat_r   <= sat_r | upd_clip;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath captures
  always_ff @(posedge clk) begin
    if (in_acc) begin
      tl_r <= in_tdata[TICK_W-1:0];
      tr_r <= in_tdata[IN_DATA_W-1:TICK_W];
    end
    if (state_r == ST_DL) begin
      dl_r <= acc_dist;
    end
    if (state_r == ST_DR) begin
      sum_r  <= SUM_W'(dl_r) + SUM_W'(acc_dist);
      diff_r <= SUM_W'(acc_dist) - SUM_W'(dl_r);
    end
    if (state_r == ST_HS) begin
      dh_r <= dh_acc[32 +: ANGLE_BITS];
    end
    if (state_r == ST_CW && cd_stat.done) begin
      cos_r <= cos_q20;
      sin_r <= sin_q20;
    end
    if (state_r == ST_YH) begin
      dx_r <= rnd_val;
    end
    if (state_r == ST_YC) begin
      dy_r <= rnd_val;
    end
    if (out_load) begin
      out_data_r <= {hout, pos_y_r, pos_x_r};
      out_user_r <= sat_r;
    end
  end

  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

`ifndef ASSERT_OFF
  a_cordic_only_mid_item: assert property (@(posedge clk) disable iff (!rst_n)
    cd_stat.busy |-> !in_tready)
    else $error("cordic busy while input is open");
`endif
`ifndef ASSERT_OFF
  a_update_starts_cordic: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && !in_tuser[0] |=> cd_stat.busy)
    else $error("update beat did not start the cordic");
`endif
`ifndef ASSERT_OFF
  a_clear_zeroes_pose: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser[0] |=>
      (state_r == ST_DONE) && (pos_x_r == '0) && (pos_y_r == '0) && (heading_r == '0))
    else $error("clear beat left pose nonzero");
`endif
`ifndef ASSERT_OFF
  a_sat_at_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |->
      (out_tdata[POS_W-1:0] == POS_MAX) || (out_tdata[POS_W-1:0] == POS_MIN) ||
      (out_tdata[2*POS_W-1:POS_W] == POS_MAX) || (out_tdata[2*POS_W-1:POS_W] == POS_MIN))
    else $error("saturation flagged with no coordinate at a limit");
`endif

endmodule

[rtl/ddo_cordic.sv]
`timescale 1ns / 1ps
// Iterative rotation-mode CORDIC: one micro-rotation per cycle, cos/sin in Q.20.
// Depends on ddo_pkg.
module ddo_cordic #(
  parameter int ANGLE_BITS   = 16,
  parameter int CORDIC_ITERS = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic [ANGLE_BITS-1:0]             angle,
  output ddo_pkg::cd_stat_t                 stat,
  output logic signed [ddo_pkg::TRIG_W-1:0] cos_q20,
  output logic signed [ddo_pkg::TRIG_W-1:0] sin_q20
);
  import ddo_pkg::*;

  localparam int CNT_W = $clog2(CORDIC_ITERS);

  cd_state_t               state_r, state_nxt;
  logic [CNT_W-1:0]        cnt_r;
  logic signed [CXY_W-1:0] x_r, y_r, z_r;
  logic                    flip_r;

  logic [31:0]             a32;
  logic                    flip_in;
  logic signed [CXY_W-1:0] z_init;
  logic signed [CXY_W-1:0] xs, ys, atan_v;
  logic signed [CXY_W-1:0] x_it, y_it, z_it;
  logic signed [CXY_W-1:0] x_rnd, y_rnd, x_shr, y_shr;
  logic                    last_iter;

  // Fold second and third quadrants by a half turn; negate at the end
  always_comb begin
    a32     = {angle, {(32 - ANGLE_BITS){1'b0}}};
    flip_in = a32[31] ^ a32[30];
    z_init  = CXY_W'($signed({a32[31] ^ flip_in, a32[30:0]}));
  end

  always_comb begin
    xs     = x_r >>> cnt_r;
    ys     = y_r >>> cnt_r;
    atan_v = CXY_W'(atan_lookup(ATAN_IDX_W'(cnt_r)));
    if (!z_r[CXY_W-1]) begin
      x_it = x_r - ys;
      y_it = y_r + xs;
      z_it = z_r - atan_v;
    end else begin
      x_it = x_r + ys;
      y_it = y_r - xs;
      z_it = z_r + atan_v;
    end
    last_iter = (cnt_r == CNT_W'(CORDIC_ITERS - 1));
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      CD_IDLE: if (start) state_nxt = CD_RUN;
      CD_RUN:  if (last_iter) state_nxt = CD_FIX;
      CD_FIX:  state_nxt = CD_DONE;
      CD_DONE: if (start) state_nxt = CD_RUN;
      default: state_nxt = CD_IDLE;
    endcase
  end

  always_comb begin
    stat.busy = (state_r == CD_RUN) || (state_r == CD_FIX);
    stat.done = (state_r == CD_DONE);
  end

  // Round half up from Q.30 to Q.20
  always_comb begin
    x_rnd   = x_r + CXY_W'(1 << (TRIG_SH - 1));
    y_rnd   = y_r + CXY_W'(1 << (TRIG_SH - 1));
    x_shr   = x_rnd >>> TRIG_SH;
    y_shr   = y_rnd >>> TRIG_SH;
    cos_q20 = x_shr[TRIG_W-1:0];
    sin_q20 = y_shr[TRIG_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= CD_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (start) begin
        cnt_r <= '0;
      end else if (state_r == CD_RUN) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x_r    <= CORDIC_K;
      y_r    <= '0;
      z_r    <= z_init;
      flip_r <= flip_in;
    end else if (state_r == CD_RUN) begin
      x_r <= x_it;
      y_r <= y_it;
      z_r <= z_it;
    end else if (state_r == CD_FIX && flip_r) begin
      x_r <= -x_r;
      y_r <= -y_r;
    end
  end

`ifndef ASSERT_OFF
  a_start_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !stat.busy)
    else $error("cordic restarted while busy");
  a_done_after_fix: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(stat.done) |-> $past(state_r) == CD_FIX)
    else $error("cordic done without fix-up step");
`endif

endmodule

[rtl/ddo_mac.sv]
`timescale 1ns / 1ps
// Shared signed multiplier with registered product and a split-operand accumulator.
// Depends on ddo_pkg.
module ddo_mac (
  input  logic                               clk,
  input  logic                               rst_n,
  input  ddo_pkg::mac_ctl_t                  ctl,
  input  logic signed [ddo_pkg::MUL_A_W-1:0] op_a,
  input  logic signed [ddo_pkg::MUL_B_W-1:0] op_b,
  output logic signed [ddo_pkg::ACC_W-1:0]   acc
);
  import ddo_pkg::*;

  mac_ctl_t                 ctl_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [ACC_W-1:0]  acc_r, acc_nxt, prod_ext;

  // Load starts a product from its low chunk; add folds in the high chunk
  always_comb begin
    prod_ext = ACC_W'(prod_r);
    priority if (ctl_r.load) begin
      acc_nxt = prod_ext;
    end else if (ctl_r.add) begin
      acc_nxt = acc_r + (prod_ext <<< SPLIT);
    end else begin
      acc_nxt = acc_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else begin
      ctl_r <= ctl;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= PROD_W'(op_a) * PROD_W'(op_b);
    acc_r  <= acc_nxt;
  end

  assign acc = acc_r;

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps
// Self-checking testbench for diff_drive_odometry_top: stream beats in, pose beats out.
// Depends on ddo_pkg (port widths, register indexes, reset values) and the RTL top.
// A cycle-free pose predictor works out each expected beat; random idling on both sides.
module tb_top;
  import ddo_pkg::*;

  // Item kinds carried in in_tuser[0]
  localparam logic KIND_UPDATE = 1'b0;
  localparam logic KIND_CLEAR  = 1'b1;

  // CORDIC seed gain in Q.30 and atan(2^-i) in 2^32-per-turn units
  localparam longint CORDIC_GAIN_Q30 = 652032874;
  localparam int     ROT_STEPS       = 16;
  localparam longint ATAN_TURN [ROT_STEPS] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772,
    166886, 83443, 41722, 20861
  };
  // Position step: Q.25 meters times Q.20 trig down to Q16.16
  localparam int     STEP_SHIFT = 29;
  localparam longint STEP_HALF  = 268435456;

  localparam int ITEMS_PER_PHASE = 241;
  localparam int N_PHASES        = 8;
  localparam int SETTLE_CYCLES   = 40;

  typedef struct packed {
    logic signed [POS_W-1:0] x_pos;
    logic signed [POS_W-1:0] y_pos;
    logic [HOUT_W-1:0]       heading_out;
    logic                    saturated;
  } pose_t;

  typedef enum logic [1:0] {
    ROW_UPDATE,
    ROW_CLEAR,
    ROW_WRITE
  } row_op_t;

  // a: left ticks or register index, b: right ticks or register value
  typedef struct packed {
    row_op_t     op;
    logic [23:0] a;
    logic [23:0] b;
    logic        known;
    pose_t       want;
  } stim_row_t;

  localparam pose_t POSE_ZERO = '{32'sd0, 32'sd0, 16'd0, 1'b0};

  // Directed rows. Only reset, clear and zero-scale rows carry a typed result;
  // the rest fall back to the predictor.
  localparam int N_DIRECTED = 33;
  localparam stim_row_t DIRECTED [N_DIRECTED] = '{
    '{ROW_UPDATE, 24'h0000,       24'h0000,       1'b1, POSE_ZERO}, // still at reset pose
    '{ROW_CLEAR,  24'h7FFF,       24'h8000,       1'b1, POSE_ZERO}, // ticks ignored on clear
    '{ROW_UPDATE, 24'h7FFF,       24'h7FFF,       1'b0, POSE_ZERO},
    '{ROW_UPDATE, 24'h8000,       24'h8000,       1'b0, POSE_ZERO},
    '{ROW_UPDATE, 24'h8000,       24'h7FFF,       1'b0, POSE_ZERO}, // hard left spin
    '{ROW_UPDATE, 24'h7FFF,       24'h8000,       1'b0, POSE_ZERO}, // hard right spin
    '{ROW_UPDATE, 24'h0001,       24'hFFFF,       1'b0, POSE_ZERO},
    '{ROW_UPDATE, 24'h0000,       24'h0064,       1'b0, POSE_ZERO},
    '{ROW_CLEAR,  24'hFFFF,       24'hFFFF,       1'b1, POSE_ZERO},
    '{ROW_WRITE,  CFG_LEFT_MPT,   24'hFFFFFF,     1'b0, POSE_ZERO},
    '{ROW_WRITE,  CFG_RIGHT_MPT,  24'hFFFFFF,     1'b0, POSE_ZERO},
    '{ROW_WRITE,  CFG_ANGLE_GAIN, 24'hFFFFFF,     1'b0, POSE_ZERO},
    '{ROW_UPDATE, 24'h7FFF,       24'h7FFF,       1'b0, POSE_ZERO},
    '{ROW_UPDATE, 24'h7FFF,       24'h7FFF,       1'b0, POSE_ZERO}, // x clips high
    '{ROW_UPDATE, 24'h8000,       24'h7FFF,       1'b0, POSE_ZERO}, // heading product wraps
    '{ROW_UPDATE, 24'h8000,       24'h8000,       1'b0, POSE_ZERO},
    '{ROW_UPDATE, 24'h8000,       24'h8000,       1'b0, POSE_ZERO},
    '{ROW_UPDATE, 24'h8000,       24'h8000,       1'b0, POSE_ZERO},
    '{ROW_CLEAR,  24'h1234,       24'hABCD,       1'b1, POSE_ZERO},
    '{ROW_WRITE,  CFG_LEFT_MPT,   24'h000000,     1'b0, POSE_ZERO},
    '{ROW_WRITE,  CFG_RIGHT_MPT,  24'h000000,     1'b0, POSE_ZERO},
    '{ROW_WRITE,  CFG_ANGLE_GAIN, 24'h000000,     1'b0, POSE_ZERO},
    '{ROW_UPDATE, 24'h7FFF,       24'h8000,       1'b1, POSE_ZERO}, // zero scale: no motion
    '{ROW_UPDATE, 24'h8000,       24'h7FFF,       1'b1, POSE_ZERO},
    '{ROW_WRITE,  CFG_RIGHT_MPT,  24'h000001,     1'b0, POSE_ZERO},
    '{ROW_WRITE,  CFG_ANGLE_GAIN, 24'hFFFFFF,     1'b0, POSE_ZERO},
    '{ROW_UPDATE, 24'h0000,       24'h7FFF,       1'b0, POSE_ZERO},
    '{ROW_UPDATE, 24'h5555,       24'h8000,       1'b0, POSE_ZERO},
    '{ROW_UPDATE, 24'hAAAA,       24'h1234,       1'b0, POSE_ZERO},
    '{ROW_WRITE,  CFG_LEFT_MPT,   RST_LEFT_MPT,   1'b0, POSE_ZERO},
    '{ROW_WRITE,  CFG_RIGHT_MPT,  RST_RIGHT_MPT,  1'b0, POSE_ZERO},
    '{ROW_WRITE,  CFG_ANGLE_GAIN, RST_ANGLE_GAIN, 1'b0, POSE_ZERO},
    '{ROW_UPDATE, 24'h0123,       24'h0456,       1'b0, POSE_ZERO}
  };

  // DUT ports; the inputs are known from time zero
  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic [0:0]            in_tuser = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [0:0]            out_tuser;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [REG_W-1:0]      cfg_data = '0;

  // Predictor copy of the registers and the pose
  logic [REG_W-1:0]        mpt_left = RST_LEFT_MPT;
  logic [REG_W-1:0]        mpt_right = RST_RIGHT_MPT;
  logic [REG_W-1:0]        turn_gain = RST_ANGLE_GAIN;
  logic signed [POS_W-1:0] est_x = '0;
  logic signed [POS_W-1:0] est_y = '0;
  logic [15:0]             est_heading = '0;

  pose_t pose_q[$];   // expected pose beats, oldest first
  int    mismatches = 0;
  bit    calm = 1'b0; // no idling on either side once set
  int    tx_rate = 4; // sender gap odds out of 16
  int    rx_rate = 4; // receiver stall odds out of 16

  diff_drive_odometry_top u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_addr   (cfg_addr),
    .cfg_data   (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Rotation-mode CORDIC on the old heading, Q.30 results rounded to Q.20.
  // Second and third quadrants are turned by a half turn, then negated.
  function automatic void heading_trig(input logic [15:0] ang,
                                       output longint cos_q20, output longint sin_q20);
    logic [31:0] a32;
    bit          flip;
    longint      cx, cy, z, xs, ys;
    a32  = {ang, 16'h0000};
    flip = (a32[31:30] == 2'b01) || (a32[31:30] == 2'b10);
    if (flip) a32 = a32 - 32'h8000_0000;
    z  = $signed(a32);
    cx = CORDIC_GAIN_Q30;
    cy = 0;
    for (int i = 0; i < ROT_STEPS; i++) begin
      xs = cx >>> i;
      ys = cy >>> i;
      if (z >= 0) begin
        cx = cx - ys;
        cy = cy + xs;
        z  = z - ATAN_TURN[i];
      end else begin
        cx = cx + ys;
        cy = cy - xs;
        z  = z + ATAN_TURN[i];
      end
    end
    if (flip) begin
      cx = -cx;
      cy = -cy;
    end
    cos_q20 = (cx + 512) >>> 10;
    sin_q20 = (cy + 512) >>> 10;
  endfunction

  // Advance the predicted pose by one item and return the beat it should produce
  function automatic pose_t advance_pose(logic kind, logic signed [15:0] lt,
                                         logic signed [15:0] rt);
    longint      dl, dr, sum, c, s, nx, ny;
    logic [63:0] turn;
    logic [31:0] dh;
    pose_t       r;
    r.saturated = 1'b0;
    if (kind == KIND_CLEAR) begin
      est_x       = '0;
      est_y       = '0;
      est_heading = '0;
    end else begin
      dl  = longint'(lt) * longint'(mpt_left);
      dr  = longint'(rt) * longint'(mpt_right);
      sum = dl + dr;
      heading_trig(est_heading, c, s);
      nx = longint'(est_x) + ((sum * c + STEP_HALF) >>> STEP_SHIFT);
      ny = longint'(est_y) + ((sum * s + STEP_HALF) >>> STEP_SHIFT);
      // clip to the 32-bit position range
      if (nx > longint'(POS_MAX)) begin nx = POS_MAX; r.saturated = 1'b1; end
      if (nx < longint'(POS_MIN)) begin nx = POS_MIN; r.saturated = 1'b1; end
      if (ny > longint'(POS_MAX)) begin ny = POS_MAX; r.saturated = 1'b1; end
      if (ny < longint'(POS_MIN)) begin ny = POS_MIN; r.saturated = 1'b1; end
      est_x = nx[31:0];
      est_y = ny[31:0];
      // heading step works modulo 2^64, then rounds half up out of the low 32 bits
      turn        = 64'(dr - dl) * 64'(turn_gain);
      dh          = (turn + 64'h8000_0000) >> 32;
      est_heading = est_heading + dh[15:0];
    end
    r.x_pos       = est_x;
    r.y_pos       = est_y;
    r.heading_out = est_heading;
    return r;
  endfunction

  task automatic check_field(string name, longint want, longint got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  // Result side: compare each accepted beat with the oldest expectation
  always @(posedge clk) begin
    pose_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pose_q.size() == 0) begin
        $error("result beat with no item outstanding");
        mismatches++;
      end else begin
        want = pose_q.pop_front();
        check_field("x_pos", want.x_pos, $signed(out_tdata[31:0]));
        check_field("y_pos", want.y_pos, $signed(out_tdata[63:32]));
        check_field("heading_out", want.heading_out, out_tdata[79:64]);
        check_field("saturated", want.saturated, out_tuser[0]);
      end
    end
  end

  // Receiver: random stall bursts, rate re-drawn now and then, none once calm
  initial begin
    int cyc;
    cyc = 0;
    forever begin
      @(posedge clk);
      cyc++;
      if (cyc % 256 == 0) begin
        case ($urandom_range(0, 2))
          0: rx_rate = 0;
          1: rx_rate = 2;
          default: rx_rate = 6;
        endcase
      end
      if (!calm && $urandom_range(0, 15) < rx_rate) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
      end
      out_tready <= 1'b1;
    end
  end

  // Drop valid and hold until every expected beat has been taken
  task automatic drain_pipeline();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pose_q.size() != 0);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [REG_W-1:0] val);
    drain_pipeline();
    cfg_valid <= 1'b1;
    cfg_addr  <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_LEFT_MPT:  mpt_left  = val;
      CFG_RIGHT_MPT: mpt_right = val;
      default:       turn_gain = val;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Present one beat; valid stays high after the handshake so back-to-back
  // items never lower and raise it in the same step.
  task automatic send_item(logic kind, logic [15:0] lt, logic [15:0] rt,
                           logic known, pose_t typed);
    pose_t p;
    if (!calm && $urandom_range(0, 15) < tx_rate) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {rt, lt};
    in_tuser  <= kind;
    do @(posedge clk); while (!in_tready);
    p = advance_pose(kind, $signed(lt), $signed(rt));
    if (known) p = typed;
    pose_q = {pose_q, p};
  endtask

  function automatic logic [REG_W-1:0] pick_reg(cfg_idx_t idx);
    logic [REG_W-1:0] dflt;
    dflt = (idx == CFG_LEFT_MPT)  ? RST_LEFT_MPT :
           (idx == CFG_RIGHT_MPT) ? RST_RIGHT_MPT : RST_ANGLE_GAIN;
    case ($urandom_range(0, 6))
      0: return '0;
      1: return '1;
      2: return dflt;
      3: return 24'($urandom);
      default: return 24'(dflt / 2 + $urandom_range(0, dflt)); // near the default
    endcase
  endfunction

  // Mostly short moves like real encoder deltas, some full-range and extreme ones
  function automatic logic [15:0] pick_ticks();
    int v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: begin
        v = int'($urandom_range(0, 600)) - 300;
        return v[15:0];
      end
      5, 6, 7: return 16'($urandom);
      8: begin
        case ($urandom_range(0, 3))
          0: return 16'h7FFF;
          1: return 16'h8000;
          2: return 16'hFFFF;
          default: return 16'h0001;
        endcase
      end
      default: return 16'h0000;
    endcase
  endfunction

  initial begin
    stim_row_t   row;
    logic [15:0] lt, rt;
    int          v;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed rows
    for (int r = 0; r < N_DIRECTED; r++) begin
      row = DIRECTED[r];
      case (row.op)
        ROW_WRITE: write_reg(cfg_idx_t'(row.a[CFG_ADDR_W-1:0]), row.b);
        ROW_CLEAR: send_item(KIND_CLEAR, row.a[15:0], row.b[15:0], row.known, row.want);
        default:   send_item(KIND_UPDATE, row.a[15:0], row.b[15:0], row.known, row.want);
      endcase
    end

    // Random phases, each under a fresh register setting; the last runs without idling
    for (int ph = 0; ph < N_PHASES; ph++) begin
      if (ph == N_PHASES - 1) calm = 1'b1;
      case ($urandom_range(0, 2))
        0: tx_rate = 0;
        1: tx_rate = 2;
        default: tx_rate = 6;
      endcase
      write_reg(CFG_LEFT_MPT, pick_reg(CFG_LEFT_MPT));
      write_reg(CFG_RIGHT_MPT, pick_reg(CFG_RIGHT_MPT));
      write_reg(CFG_ANGLE_GAIN, pick_reg(CFG_ANGLE_GAIN));
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        lt = pick_ticks();
        rt = pick_ticks();
        // straight-ish driving: right wheel close to the left one
        if ($urandom_range(0, 3) == 0) begin
          v  = int'($signed(lt)) + int'($urandom_range(0, 40)) - 20;
          rt = v[15:0];
        end
        if ($urandom_range(0, 99) < 3)
          send_item(KIND_CLEAR, lt, rt, 1'b0, POSE_ZERO);
        else
          send_item(KIND_UPDATE, lt, rt, 1'b0, POSE_ZERO);
        // now and then let the block run dry before the next beat
        if (!calm && $urandom_range(0, 149) == 0) drain_pipeline();
      end
    end

    in_tvalid <= 1'b0;
    while (pose_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pose_q.size() == 0 && mismatches == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

  // Watchdog: well past the slowest correct run
  initial begin
    #2_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule

[sim.f]
rtl/ddo_pkg.sv
rtl/ddo_cordic.sv
rtl/ddo_mac.sv
rtl/diff_drive_odometry_top.sv
tb/tb_top.sv
